// File: rtl/cpg_pkg.sv
// ----------------------------------------------------------------------------
// cpg_pkg: shared constants for the circle point generator
// Widths, CORDIC constants, arctangent table and register map.
// ----------------------------------------------------------------------------
package cpg_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_TABLE_LEN = 24;
  localparam int CORDIC_N = (CORDIC_STEPS < CORDIC_TABLE_LEN) ? CORDIC_STEPS
                                                              : CORDIC_TABLE_LEN;

  localparam int DW = 16;  // field width
  localparam int CW = 33;  // CORDIC datapath, Q2.30 plus headroom

  localparam logic signed [CW-1:0] GAIN_Q30 = 33'sd652032874;
  localparam logic [CW-1:0]        PI_Q31   = 33'd6746518852;

  localparam int AW = 4;   // byte address width of the register port

  typedef enum logic [1:0] {
    REG_RADIUS      = 2'd0,
    REG_PHASE_STEP  = 2'd1,
    REG_START_PHASE = 2'd2,
    REG_LAST_INDEX  = 2'd3
  } reg_idx_t;

  // arctangent of 2^-i, radians in Q2.30, truncated
  function automatic logic signed [CW-1:0] atan_q30(input int i);
    logic signed [CW-1:0] v;
    v = '0;
    unique case (i)
      0:  v = 33'sd843314856;
      1:  v = 33'sd497837829;
      2:  v = 33'sd263043836;
      3:  v = 33'sd133525158;
      4:  v = 33'sd67021686;
      5:  v = 33'sd33543515;
      6:  v = 33'sd16775850;
      7:  v = 33'sd8388437;
      8:  v = 33'sd4194282;
      9:  v = 33'sd2097149;
      10: v = 33'sd1048575;
      11: v = 33'sd524287;
      12: v = 33'sd262143;
      13: v = 33'sd131071;
      14: v = 33'sd65535;
      15: v = 33'sd32767;
      16: v = 33'sd16383;
      17: v = 33'sd8191;
      18: v = 33'sd4095;
      19: v = 33'sd2047;
      20: v = 33'sd1023;
      21: v = 33'sd511;
      22: v = 33'sd255;
      23: v = 33'sd127;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/circle_point_generator.sv
// ----------------------------------------------------------------------------
// circle_point_generator: sampled circle from a quadrature DDS
// Phase accumulator, pipelined rotation CORDIC and Q8.8 radius scaling.
// ----------------------------------------------------------------------------
// Pipeline: CORDIC_N + 4 register stages from input accept to out_valid:
//   phase, quadrant, CORDIC steps, rounding, radius.
// Throughput: one word per clock while out_stall is low; a stage holds only while the stage after it
//   is full and stalled, so bubbles collapse under out_stall.
// Reset: registers return to defaults, sample count and phase clear, pipeline empties.
module circle_point_generator (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_restart,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [cpg_pkg::DW-1:0]    out_x_pos,
  output logic signed [cpg_pkg::DW-1:0]    out_y_pos,
  output logic        [cpg_pkg::DW-1:0]    out_sample_index,
  output logic                             out_last,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic        [cpg_pkg::AW-1:0]    paddr,
  input  logic        [31:0]               pwdata,
  output logic        [31:0]               prdata,
  output logic                             pready
);
  import cpg_pkg::*;

  localparam int NS = CORDIC_N + 4;  // pipeline stages
  localparam int SQ = CORDIC_N + 2;  // quadrant map stage
  localparam int SO = CORDIC_N + 3;  // output stage

  // ---------------- register port ----------------
  logic [DW-1:0] radius_r, phase_step_r, start_phase_r, last_index_r;
  reg_idx_t      reg_sel;
  logic          wr_en;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[AW-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r      <= 16'd256;
      phase_step_r  <= 16'd1310;
      start_phase_r <= 16'd20861;
      last_index_r  <= 16'd100;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_RADIUS:      radius_r      <= pwdata[DW-1:0];
        REG_PHASE_STEP:  phase_step_r  <= pwdata[DW-1:0];
        REG_START_PHASE: start_phase_r <= pwdata[DW-1:0];
        REG_LAST_INDEX:  last_index_r  <= pwdata[DW-1:0];
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_RADIUS:      prdata[DW-1:0] = radius_r;
      REG_PHASE_STEP:  prdata[DW-1:0] = phase_step_r;
      REG_START_PHASE: prdata[DW-1:0] = start_phase_r;
      REG_LAST_INDEX:  prdata[DW-1:0] = last_index_r;
    endcase
  end

  // ---------------- pipeline flow control ----------------
  logic [NS-1:0] vld_r;
  logic [NS-1:0] rdy;
  logic [NS-1:0] vin;
  logic [NS-1:0] ld;

  assign rdy[NS-1] = !vld_r[NS-1] || !out_stall;
  assign vin[0]    = in_valid;

  for (genvar k = 0; k < NS - 1; k++) begin : g_rdy
    assign rdy[k]   = !vld_r[k] || rdy[k+1];
    assign vin[k+1] = vld_r[k];
  end

  assign ld       = rdy & vin;
  assign in_stall = !rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) vld_r[k] <= vin[k];
      end
    end
  end

  // ---------------- sample counter and phase ----------------
  logic [DW-1:0] sample_count_r, sample_count_nxt;
  logic [DW-1:0] phase_offset_r, phase_offset_nxt;
  logic [DW-1:0] cur_idx, cur_off;
  logic          cur_last;

  logic [DW-1:0] idx_r  [NS];
  logic          last_r [NS];
  logic [DW-1:0] ph_r;

  assign cur_idx  = in_restart ? '0 : sample_count_r;
  assign cur_off  = in_restart ? '0 : phase_offset_r;
  assign cur_last = (cur_idx == last_index_r);

  assign sample_count_nxt = cur_last ? '0 : cur_idx + 16'd1;
  assign phase_offset_nxt = cur_last ? '0 : cur_off + phase_step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r <= '0;
      phase_offset_r <= '0;
    end else if (ld[0]) begin
      sample_count_r <= sample_count_nxt;
      phase_offset_r <= phase_offset_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      ph_r      <= start_phase_r + cur_off;
      idx_r[0]  <= cur_idx;
      last_r[0] <= cur_last;
    end
  end

  // index and last flag ride along with the data
  for (genvar k = 1; k < NS; k++) begin : g_meta
    always_ff @(posedge clk) begin
      if (ld[k]) begin
        idx_r[k]  <= idx_r[k-1];
        last_r[k] <= last_r[k-1];
      end
    end
  end

  // ---------------- quadrant reduction ----------------
  logic signed [CW-1:0] cx_r [CORDIC_N+1];
  logic signed [CW-1:0] cy_r [CORDIC_N+1];
  logic signed [CW-1:0] cz_r [CORDIC_N+1];
  logic        [1:0]    quad_r [CORDIC_N+1];

  logic [DW-1:0]        ph_bias;
  logic [1:0]           quad;
  logic signed [DW-1:0] res;
  logic [13:0]          mag;
  logic [46:0]          zprod;
  logic signed [CW-1:0] zmag;

  assign ph_bias = ph_r + 16'h2000;
  assign quad    = ph_bias[15:14];
  assign res     = $signed(ph_r - {quad, 14'b0});
  // |res| never exceeds an eighth turn, so 14 bits suffice
  assign mag     = res[DW-1] ? 14'(-res) : res[13:0];
  assign zprod   = 47'(mag) * 47'(PI_Q31);
  assign zmag    = $signed({2'b00, zprod[46:16]});

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      cx_r[0]   <= GAIN_Q30;
      cy_r[0]   <= '0;
      cz_r[0]   <= res[DW-1] ? -zmag : zmag;
      quad_r[0] <= quad;
    end
  end

  // ---------------- CORDIC rotation stages ----------------
  for (genvar j = 0; j < CORDIC_N; j++) begin : g_cordic
    logic signed [CW-1:0] dx, dy;
    assign dx = cy_r[j] >>> j;
    assign dy = cx_r[j] >>> j;

    always_ff @(posedge clk) begin
      if (ld[j+2]) begin
        quad_r[j+1] <= quad_r[j];
        if (!cz_r[j][CW-1]) begin
          cx_r[j+1] <= cx_r[j] - dx;
          cy_r[j+1] <= cy_r[j] + dy;
          cz_r[j+1] <= cz_r[j] - atan_q30(j);
        end else begin
          cx_r[j+1] <= cx_r[j] + dx;
          cy_r[j+1] <= cy_r[j] - dy;
          cz_r[j+1] <= cz_r[j] + atan_q30(j);
        end
      end
    end
  end

  // ---------------- quadrant map, round to Q1.15 ----------------
  function automatic logic signed [DW-1:0] round_q15(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] t;
    logic signed [17:0]   r;
    logic signed [DW-1:0] o;
    t = v + 33'sd16384;
    r = 18'(t >>> 15);
    if (r > 18'sd32767)       o = 16'sd32767;
    else if (r < -18'sd32767) o = -16'sd32767;
    else                      o = r[DW-1:0];
    return o;
  endfunction

  logic signed [CW-1:0] cos_v, sin_v;
  logic signed [DW-1:0] c15_r, s15_r;

  always_comb begin
    unique case (quad_r[CORDIC_N])
      2'd0: begin cos_v =  cx_r[CORDIC_N]; sin_v =  cy_r[CORDIC_N]; end
      2'd1: begin cos_v = -cy_r[CORDIC_N]; sin_v =  cx_r[CORDIC_N]; end
      2'd2: begin cos_v = -cx_r[CORDIC_N]; sin_v = -cy_r[CORDIC_N]; end
      default: begin cos_v = cy_r[CORDIC_N]; sin_v = -cx_r[CORDIC_N]; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld[SQ]) begin
      c15_r <= round_q15(cos_v);
      s15_r <= round_q15(sin_v);
    end
  end

  // ---------------- radius scaling ----------------
  function automatic logic signed [DW-1:0] scale_q15(input logic signed [32:0] p);
    logic signed [32:0] t;
    logic signed [17:0] r;
    logic signed [DW-1:0] o;
    t = p + 33'sd16384;
    r = 18'(t >>> 15);
    if (r > 18'sd32767)       o = 16'sd32767;
    else if (r < -18'sd32768) o = -16'sd32768;
    else                      o = r[DW-1:0];
    return o;
  endfunction

  logic signed [16:0]   rad_s;
  logic signed [32:0]   xprod, yprod;
  logic signed [DW-1:0] x_r, y_r;

  assign rad_s = $signed({1'b0, radius_r});
  assign xprod = rad_s * c15_r;
  assign yprod = rad_s * s15_r;

  always_ff @(posedge clk) begin
    if (ld[SO]) begin
      x_r <= scale_q15(xprod);
      y_r <= scale_q15(yprod);
    end
  end

  assign out_valid        = vld_r[SO];
  assign out_x_pos        = x_r;
  assign out_y_pos        = y_r;
  assign out_sample_index = idx_r[SO];
  assign out_last         = last_r[SO];

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: circle point generator check
// Drives tick words with random gaps and output stalls, predicts every point
// with a bit-exact CORDIC model kept in the bench, and compares each result
// word field by field. Registers are rewritten between phases while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import cpg_pkg::*;

  localparam int LATENCY        = CORDIC_N + 4;
  localparam int ITERS          = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
  localparam int CYCLE_LIMIT    = 600000;
  localparam int RANDOM_WORDS   = 440;
  localparam int SQUEEZE_CYCLES = 300;
  localparam int ERR_SHOWN      = 40;

  localparam longint ROT_GAIN = 64'sd652032874;   // 0.607253 in Q2.30
  localparam longint PI_RAD   = 64'sd6746518852;  // pi in Q2.31

  localparam logic [3:0] CHK_X    = 4'd1;
  localparam logic [3:0] CHK_Y    = 4'd2;
  localparam logic [3:0] CHK_IDX  = 4'd4;
  localparam logic [3:0] CHK_LAST = 4'd8;

  typedef enum logic { ROW_WORD, ROW_REG } row_kind_t;

  typedef struct packed {
    logic signed [15:0] x_pos;
    logic signed [15:0] y_pos;
    logic        [15:0] sample_index;
    logic               last;
  } point_t;

  typedef struct packed {
    row_kind_t   kind;
    reg_idx_t    ridx;
    logic [31:0] wdata;
    logic        restart;
    logic [3:0]  chk;
    point_t      typed;
  } row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_restart;
  logic                 out_valid;
  logic                 out_stall;
  logic signed [DW-1:0] out_x_pos;
  logic signed [DW-1:0] out_y_pos;
  logic        [DW-1:0] out_sample_index;
  logic                 out_last;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [AW-1:0]        paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  // arctangent of 2^-i in radians, Q2.30, truncated
  longint arctan_tab [24] = '{
    843314856, 497837829, 263043836, 133525158, 67021686,
    33543515, 16775850, 8388437, 4194282, 2097149,
    1048575, 524287, 262143, 131071, 65535,
    32767, 16383, 8191, 4095, 2047,
    1023, 511, 255, 127
  };

  // predictor copy of registers and state
  logic [15:0] radius_q, step_q, start_q, last_q;
  logic [15:0] count_q, offset_q;

  point_t points_due [$];
  row_t   script [$];

  int  err_count;
  int  words_sent;
  int  words_checked;
  int  reg_writes;
  int  cycle_count;
  bit  calm_tx;
  bit  calm_rx;
  bit  squeeze_req;

  circle_point_generator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_restart       (in_restart),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_x_pos        (out_x_pos),
    .out_y_pos        (out_y_pos),
    .out_sample_index (out_sample_index),
    .out_last         (out_last),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still due", cycle_count,
               points_due.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic void cordic_cos_sin(input logic [15:0] phase, output longint c15,
                                         output longint s15);
    int     quad, i;
    longint res, mag, z, x, y, dx, dy, c, s;
    quad = ((int'(phase) + 'h2000) >> 14) & 3;
    res  = phase;
    res  = res - quad * 16384;
    if (res >= 32768) res = res - 65536;
    mag = (res < 0) ? -res : res;
    z   = (mag * PI_RAD) >>> 16;
    if (res < 0) z = -z;
    x = ROT_GAIN;
    y = 0;
    for (i = 0; i < ITERS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - arctan_tab[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + arctan_tab[i];
      end
    end
    case (quad)
      0: begin
        c = x;
        s = y;
      end
      1: begin
        c = -y;
        s = x;
      end
      2: begin
        c = -x;
        s = -y;
      end
      default: begin
        c = y;
        s = -x;
      end
    endcase
    c15 = clip((c + 16384) >>> 15, -32767, 32767);
    s15 = clip((s + 16384) >>> 15, -32767, 32767);
  endfunction

  function automatic logic [15:0] scale_q88(input longint v15);
    longint r;
    r = radius_q;
    return 16'(clip((r * v15 + 16384) >>> 15, -32768, 32767));
  endfunction

  // next point on the circle; advances the sample counter and phase offset
  function automatic point_t next_point(input bit restart);
    point_t      p;
    logic [15:0] phase;
    longint      c, s;
    if (restart) begin
      count_q  = '0;
      offset_q = '0;
    end
    phase = start_q + offset_q;
    cordic_cos_sin(phase, c, s);
    p.x_pos        = scale_q88(c);
    p.y_pos        = scale_q88(s);
    p.sample_index = count_q;
    p.last         = (count_q == last_q);
    if (p.last) begin
      count_q  = '0;
      offset_q = '0;
    end else begin
      count_q  = count_q + 16'd1;
      offset_q = offset_q + step_q;
    end
    return p;
  endfunction

  function automatic int idle_len(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] pick_value(input reg_idx_t idx);
    int r;
    r = $urandom_range(0, 9);
    case (idx)
      REG_LAST_INDEX: begin
        if (r == 0) return 16'hFFFF;
        if (r == 1) return 16'd0;
        if (r == 2) return 16'd1;
        if (r == 3) return 16'($urandom);
        return 16'($urandom_range(2, 30));
      end
      REG_RADIUS: begin
        if (r == 0) return 16'hFFFF;
        if (r == 1) return 16'd0;
        if (r == 2) return 16'd256;
        return 16'($urandom);
      end
      default: begin
        if (r == 0) return 16'hFFFF;
        if (r == 1) return 16'd0;
        return 16'($urandom);
      end
    endcase
  endfunction

  task automatic flag_field(input string field, input longint want, input longint got);
    err_count++;
    if (err_count <= ERR_SHOWN)
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
  endtask

  task automatic add_word(input bit restart, input logic [3:0] chk, input int x,
                          input int y, input int idx, input bit last);
    row_t r;
    r                    = '0;
    r.kind               = ROW_WORD;
    r.restart            = restart;
    r.chk                = chk;
    r.typed.x_pos        = 16'(x);
    r.typed.y_pos        = 16'(y);
    r.typed.sample_index = 16'(idx);
    r.typed.last         = last;
    script = {script, r};
  endtask

  task automatic add_reg(input reg_idx_t idx, input logic [31:0] data);
    row_t r;
    r       = '0;
    r.kind  = ROW_REG;
    r.ridx  = idx;
    r.wdata = data;
    script = {script, r};
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AW'(idx) << 2;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    case (idx)
      REG_RADIUS:      radius_q = data[15:0];
      REG_PHASE_STEP:  step_q   = data[15:0];
      REG_START_PHASE: start_q  = data[15:0];
      REG_LAST_INDEX:  last_q   = data[15:0];
    endcase
    reg_writes++;
    // read it back
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    if (prdata[15:0] !== data[15:0]) flag_field("prdata", data[15:0], prdata[15:0]);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // one tick word; waits for the accepting edge, then drops in_valid and idles for the requested gap
  task automatic send_word(input bit restart, input logic [3:0] chk, input point_t typed,
                           input int gap, output point_t pt);
    @(negedge clk);
    in_valid   <= 1'b1;
    in_restart <= restart;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    pt = next_point(restart);
    if (chk & CHK_X)    pt.x_pos        = typed.x_pos;
    if (chk & CHK_Y)    pt.y_pos        = typed.y_pos;
    if (chk & CHK_IDX)  pt.sample_index = typed.sample_index;
    if (chk & CHK_LAST) pt.last         = typed.last;
    points_due = {points_due, pt};
    words_sent++;
    if (gap > 0) begin
      @(negedge clk);
      in_valid   <= 1'b0;
      in_restart <= 1'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // drain the pipeline before touching registers
  task automatic settle();
    if (in_valid) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    while (points_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  always @(posedge clk) begin : result_check
    point_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (points_due.size() == 0) begin
        err_count++;
        if (err_count <= ERR_SHOWN)
          $error("unexpected word: index %0d x %0d y %0d", out_sample_index, out_x_pos,
                 out_y_pos);
      end else begin
        want = points_due.pop_front();
        words_checked++;
        if (out_x_pos !== want.x_pos) flag_field("x_pos", want.x_pos, out_x_pos);
        if (out_y_pos !== want.y_pos) flag_field("y_pos", want.y_pos, out_y_pos);
        if (out_sample_index !== want.sample_index)
          flag_field("sample_index", want.sample_index, out_sample_index);
        if (out_last !== want.last) flag_field("last", want.last, out_last);
      end
    end
  end

  // output back-pressure, with one long hold when asked
  initial begin : receiver
    int hold;
    hold = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold == 0) begin
        if (squeeze_req) begin
          hold        = SQUEEZE_CYCLES;
          squeeze_req = 1'b0;
        end else begin
          hold = idle_len(calm_rx);
        end
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    row_t   r;
    point_t pt;
    int     phase_n, words, n, restart_odds;

    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_restart  = 1'b0;
    out_stall   = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    err_count   = 0;
    words_sent  = 0;
    words_checked = 0;
    reg_writes  = 0;
    cycle_count = 0;
    calm_tx     = 1'b0;
    calm_rx     = 1'b0;
    squeeze_req = 1'b0;
    radius_q    = 16'd256;
    step_q      = 16'd1310;
    start_q     = 16'd20861;
    last_q      = 16'd100;
    count_q     = '0;
    offset_q    = '0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // defaults after reset, then a short circle
    add_word(1'b0, CHK_IDX | CHK_LAST, 0, 0, 0, 1'b0);
    add_word(1'b0, CHK_IDX | CHK_LAST, 0, 0, 1, 1'b0);
    add_word(1'b1, CHK_IDX | CHK_LAST, 0, 0, 0, 1'b0);
    add_reg(REG_LAST_INDEX, 32'hABCD_0002);  // upper bits must be dropped
    add_word(1'b0, CHK_IDX | CHK_LAST, 0, 0, 1, 1'b0);
    add_word(1'b0, CHK_IDX | CHK_LAST, 0, 0, 2, 1'b1);
    add_word(1'b0, CHK_IDX | CHK_LAST, 0, 0, 0, 1'b0);
    // zero radius collapses the circle
    add_reg(REG_RADIUS, 32'h0000_0000);
    add_word(1'b0, CHK_X | CHK_Y | CHK_IDX | CHK_LAST, 0, 0, 1, 1'b0);
    // full radius at quarter turns saturates each axis
    add_reg(REG_RADIUS, 32'h0000_FFFF);
    add_reg(REG_START_PHASE, 32'h0000_0000);
    add_reg(REG_PHASE_STEP, 32'h0000_4000);
    add_reg(REG_LAST_INDEX, 32'hFFFF_FFFF);
    add_word(1'b1, CHK_X | CHK_IDX | CHK_LAST, 32767, 0, 0, 1'b0);
    add_word(1'b0, CHK_Y | CHK_IDX, 0, 32767, 1, 1'b0);
    add_word(1'b0, CHK_X | CHK_IDX, -32768, 0, 2, 1'b0);
    add_word(1'b0, CHK_Y | CHK_IDX, 0, -32768, 3, 1'b0);
    // last index dropped below the running count
    add_reg(REG_LAST_INDEX, 32'h0000_0002);
    add_word(1'b0, CHK_IDX | CHK_LAST, 0, 0, 4, 1'b0);
    add_word(1'b1, CHK_IDX | CHK_LAST, 0, 0, 0, 1'b0);
    add_word(1'b0, CHK_IDX | CHK_LAST, 0, 0, 1, 1'b0);
    add_word(1'b0, CHK_IDX | CHK_LAST, 0, 0, 2, 1'b1);
    // zero intervals: every tick is the last sample
    add_reg(REG_LAST_INDEX, 32'h0000_0000);
    add_word(1'b0, CHK_IDX | CHK_LAST, 0, 0, 0, 1'b1);
    add_word(1'b1, CHK_IDX | CHK_LAST, 0, 0, 0, 1'b1);

    foreach (script[i]) begin
      r = script[i];
      if (r.kind == ROW_REG) begin
        settle();
        write_reg(r.ridx, r.wdata);
      end else begin
        send_word(r.restart, r.chk, r.typed, idle_len(calm_tx), pt);
      end
    end

    // random setups
    phase_n = 0;
    words   = 0;
    while (words < RANDOM_WORDS) begin
      settle();
      phase_n++;
      calm_tx = ($urandom_range(0, 3) == 0);
      calm_rx = ($urandom_range(0, 3) == 0);
      n       = $urandom_range(10, 50);
      if (phase_n == 3) begin
        calm_tx     = 1'b1;
        squeeze_req = 1'b1;
        n           = 80;
      end
      restart_odds = ($urandom_range(0, 4) == 0) ? 3 : 24;
      if (phase_n == 1 || $urandom_range(0, 1))
        write_reg(REG_RADIUS, {16'($urandom), pick_value(REG_RADIUS)});
      if (phase_n == 1 || $urandom_range(0, 1))
        write_reg(REG_PHASE_STEP, {16'($urandom), pick_value(REG_PHASE_STEP)});
      if (phase_n == 1 || $urandom_range(0, 1))
        write_reg(REG_START_PHASE, {16'($urandom), pick_value(REG_START_PHASE)});
      if (phase_n == 1 || $urandom_range(0, 1))
        write_reg(REG_LAST_INDEX, {16'($urandom), pick_value(REG_LAST_INDEX)});
      repeat (n) begin
        send_word($urandom_range(0, restart_odds - 1) == 0, '0, '0, idle_len(calm_tx), pt);
        words++;
      end
    end

    // last index lowered below a running count: the index keeps counting
    settle();
    calm_tx = 1'b1;
    calm_rx = 1'b1;
    write_reg(REG_LAST_INDEX, 32'h0000_FFFF);
    send_word(1'b1, '0, '0, 0, pt);
    repeat (40) send_word(1'b0, '0, '0, 0, pt);
    settle();
    write_reg(REG_LAST_INDEX, 32'h0000_0007);
    repeat (20) send_word(1'b0, '0, '0, 0, pt);
    send_word(1'b1, '0, '0, 0, pt);
    repeat (8) send_word(1'b0, '0, '0, 0, pt);
    settle();
    repeat (LATENCY * 2) @(posedge clk);

    $display("Checked %0d of %0d words over %0d random setups and %0d register writes,",
             words_checked, words_sent, phase_n, reg_writes);
    $display("including a long output hold and a last index set below a running count.");
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
